// ===== design/ebalu_pkg.sv =====
// ebalu_pkg: operation codes, flag and result types for the eight-bit alu
// no dependencies; used by ebalu_exec and eight_bit_alu_with_flags_unit

package ebalu_pkg;

  typedef enum logic [4:0] {
    MODE_ADD  = 5'd0,
    MODE_ADC  = 5'd1,
    MODE_SUB  = 5'd2,
    MODE_SBC  = 5'd3,
    MODE_AND  = 5'd4,
    MODE_XOR  = 5'd5,
    MODE_OR   = 5'd6,
    MODE_CP   = 5'd7,
    MODE_INC  = 5'd8,
    MODE_DEC  = 5'd9,
    MODE_DAA  = 5'd10,
    MODE_CPL  = 5'd11,
    MODE_SCF  = 5'd12,
    MODE_CCF  = 5'd13,
    MODE_RLCA = 5'd14,
    MODE_RRCA = 5'd15,
    MODE_RLA  = 5'd16,
    MODE_RRA  = 5'd17,
    MODE_RLC  = 5'd18,
    MODE_RRC  = 5'd19,
    MODE_RL   = 5'd20,
    MODE_RR   = 5'd21,
    MODE_SLA  = 5'd22,
    MODE_SRA  = 5'd23,
    MODE_SWAP = 5'd24,
    MODE_SRL  = 5'd25,
    MODE_BIT  = 5'd26,
    MODE_RES  = 5'd27,
    MODE_SET  = 5'd28,
    MODE_LOAD = 5'd29
  } mode_e;

  // shift kinds, shared by the accumulator rotates and the prefixed group
  typedef enum logic [2:0] {
    SH_RLC  = 3'd0,
    SH_RRC  = 3'd1,
    SH_RL   = 3'd2,
    SH_RR   = 3'd3,
    SH_SLA  = 3'd4,
    SH_SRA  = 3'd5,
    SH_SWAP = 3'd6,
    SH_SRL  = 3'd7
  } shift_e;

  // packed so that z is bit 3 and c is bit 0
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [7:0] result;
    logic [7:0] acc;
    flags_t     flags;
  } alu_out_t;

  localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
  localparam logic [3:0] DAA_LO_LIMIT = 4'h9;
  localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
  localparam logic [7:0] DAA_LO_ADJ   = 8'h06;

endpackage

// ===== design/eight_bit_alu_with_flags_unit.sv =====
// eight_bit_alu_with_flags_unit: top level, input register, accumulator and flags,
// result register; depends on ebalu_pkg and ebalu_exec
//
//   channel  dir  width (tdata / tuser)  contents
//   s_axis   in   16 / 5                 operand, bit_index, flags_in / mode
//   m_axis   out  24 / -                 result, accumulator_out, z, n, h, c
//
// one beat per cycle while m_axis_tready holds; a beat passes the input register,
// then the combinational alu, then the result register that drives m_axis;
// accumulator and flags update in the same edge that loads the result register
// a stalled result holds both stages; s_axis_tready drops only when both are full
// reset clears the accumulator, the flags and both valid bits

module eight_bit_alu_with_flags_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] operand, [10:8] bit_index, [14:11] flags_in
  input  logic [4:0]  s_axis_tuser,  // [4:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // [7:0] result, [15:8] accumulator_out, [16] zero,
                                     // [17] subtract, [18] half_carry, [19] carry
);
  import ebalu_pkg::*;

  logic       in_valid_q;
  logic [4:0] mode_q;
  logic [7:0] operand_q;
  logic [2:0] bit_index_q;
  logic [3:0] flags_in_q;

  logic       out_valid_q;
  logic [7:0] result_q;
  logic [7:0] acc_q;
  flags_t     flags_q;

  logic       advance;
  alu_out_t   alu_out;

  // input stage moves on when the result register is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      mode_q      <= s_axis_tuser;
      operand_q   <= s_axis_tdata[7:0];
      bit_index_q <= s_axis_tdata[10:8];
      flags_in_q  <= s_axis_tdata[14:11];
    end
  end

  ebalu_exec u_exec (
    .mode_i      (mode_q),
    .operand_i   (operand_q),
    .bit_index_i (bit_index_q),
    .flags_in_i  (flags_in_q),
    .acc_i       (acc_q),
    .flags_i     (flags_q),
    .out_o       (alu_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      acc_q       <= 8'd0;
      flags_q     <= '0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        acc_q       <= alu_out.acc;
        flags_q     <= alu_out.flags;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= alu_out.result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, flags_q.c, flags_q.h, flags_q.n, flags_q.z, acc_q, result_q};

  a_ready_when_out_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input not ready while result register empty");

  a_full_stall_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while both stages are stalled");

  a_state_holds_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(acc_q) && $stable(flags_q)))
    else $error("accumulator or flags changed without an operation");

  a_advance_fills_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("operation retired without a result beat");

endmodule

// ===== design/ebalu_exec.sv =====
// ebalu_exec: combinational datapath for one alu operation
// depends on ebalu_pkg for codes and flag types

module ebalu_exec (
  input  logic [4:0]       mode_i,
  input  logic [7:0]       operand_i,
  input  logic [2:0]       bit_index_i,
  input  logic [3:0]       flags_in_i,
  input  logic [7:0]       acc_i,
  input  ebalu_pkg::flags_t flags_i,
  output ebalu_pkg::alu_out_t out_o
);
  import ebalu_pkg::*;

  logic       carry_in;
  logic [8:0] add_sum;
  logic [4:0] add_half;
  logic [8:0] sub_diff;
  logic [4:0] sub_half;
  logic [7:0] inc_val;
  logic [7:0] dec_val;
  logic [7:0] daa_val;
  logic       daa_carry;
  logic [7:0] bit_mask;
  logic [7:0] sh_src;
  logic [7:0] sh_val;
  logic       sh_carry;
  shift_e     sh_kind;
  logic       is_acc_rot;

  assign carry_in = ((mode_i == MODE_ADC) || (mode_i == MODE_SBC)) ? flags_i.c : 1'b0;
  assign add_sum  = {1'b0, acc_i} + {1'b0, operand_i} + {8'd0, carry_in};
  assign add_half = {1'b0, acc_i[3:0]} + {1'b0, operand_i[3:0]} + {4'd0, carry_in};
  assign sub_diff = {1'b0, acc_i} - {1'b0, operand_i} - {8'd0, carry_in};
  assign sub_half = {1'b0, acc_i[3:0]} - {1'b0, operand_i[3:0]} - {4'd0, carry_in};
  assign inc_val  = operand_i + 8'd1;
  assign dec_val  = operand_i - 8'd1;
  assign bit_mask = 8'd1 << bit_index_i;

  // decimal adjust after add or subtract
  always_comb begin
    daa_val   = acc_i;
    daa_carry = flags_i.c;
    if (!flags_i.n) begin
      if (flags_i.c || (acc_i > DAA_HI_LIMIT)) begin
        daa_val   = daa_val + DAA_HI_ADJ;
        daa_carry = 1'b1;
      end
      if (flags_i.h || (acc_i[3:0] > DAA_LO_LIMIT)) begin
        daa_val = daa_val + DAA_LO_ADJ;
      end
    end else begin
      if (flags_i.h) begin
        daa_val = daa_val - DAA_LO_ADJ;
      end
      if (flags_i.c) begin
        daa_val = daa_val - DAA_HI_ADJ;
      end
    end
  end

  // one shifter serves both rotate groups
  assign is_acc_rot = (mode_i <= MODE_RRA);
  assign sh_src     = is_acc_rot ? acc_i : operand_i;
  assign sh_kind    = is_acc_rot ? shift_e'(3'(mode_i - MODE_RLCA))
                                 : shift_e'(3'(mode_i - MODE_RLC));

  always_comb begin
    sh_carry = sh_src[0];
    sh_val   = {1'b0, sh_src[7:1]};
    case (sh_kind)
      SH_RLC: begin
        sh_carry = sh_src[7];
        sh_val   = {sh_src[6:0], sh_src[7]};
      end
      SH_RRC: begin
        sh_carry = sh_src[0];
        sh_val   = {sh_src[0], sh_src[7:1]};
      end
      SH_RL: begin
        sh_carry = sh_src[7];
        sh_val   = {sh_src[6:0], flags_i.c};
      end
      SH_RR: begin
        sh_carry = sh_src[0];
        sh_val   = {flags_i.c, sh_src[7:1]};
      end
      SH_SLA: begin
        sh_carry = sh_src[7];
        sh_val   = {sh_src[6:0], 1'b0};
      end
      SH_SRA: begin
        sh_carry = sh_src[0];
        sh_val   = {sh_src[7], sh_src[7:1]};
      end
      SH_SWAP: begin
        sh_carry = 1'b0;
        sh_val   = {sh_src[3:0], sh_src[7:4]};
      end
      default: begin
        sh_carry = sh_src[0];
        sh_val   = {1'b0, sh_src[7:1]};
      end
    endcase
  end

  always_comb begin
    out_o.result = acc_i;
    out_o.acc    = acc_i;
    out_o.flags  = flags_i;
    unique case (mode_i)
      MODE_ADD, MODE_ADC: begin
        out_o.acc    = add_sum[7:0];
        out_o.result = add_sum[7:0];
        out_o.flags  = '{z: (add_sum[7:0] == 8'd0), n: 1'b0, h: add_half[4], c: add_sum[8]};
      end
      MODE_SUB, MODE_SBC: begin
        out_o.acc    = sub_diff[7:0];
        out_o.result = sub_diff[7:0];
        out_o.flags  = '{z: (sub_diff[7:0] == 8'd0), n: 1'b1, h: sub_half[4], c: sub_diff[8]};
      end
      MODE_CP: begin
        out_o.flags = '{z: (sub_diff[7:0] == 8'd0), n: 1'b1, h: sub_half[4], c: sub_diff[8]};
      end
      MODE_AND: begin
        out_o.acc    = acc_i & operand_i;
        out_o.result = acc_i & operand_i;
        out_o.flags  = '{z: ((acc_i & operand_i) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      MODE_XOR: begin
        out_o.acc    = acc_i ^ operand_i;
        out_o.result = acc_i ^ operand_i;
        out_o.flags  = '{z: ((acc_i ^ operand_i) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      MODE_OR: begin
        out_o.acc    = acc_i | operand_i;
        out_o.result = acc_i | operand_i;
        out_o.flags  = '{z: ((acc_i | operand_i) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      MODE_INC: begin
        out_o.result = inc_val;
        out_o.flags  = '{z: (inc_val == 8'd0), n: 1'b0, h: (inc_val[3:0] == 4'd0),
                         c: flags_i.c};
      end
      MODE_DEC: begin
        out_o.result = dec_val;
        out_o.flags  = '{z: (dec_val == 8'd0), n: 1'b1, h: (operand_i[3:0] == 4'd0),
                         c: flags_i.c};
      end
      MODE_DAA: begin
        out_o.acc    = daa_val;
        out_o.result = daa_val;
        out_o.flags  = '{z: (daa_val == 8'd0), n: flags_i.n, h: 1'b0, c: daa_carry};
      end
      MODE_CPL: begin
        out_o.acc     = ~acc_i;
        out_o.result  = ~acc_i;
        out_o.flags.n = 1'b1;
        out_o.flags.h = 1'b1;
      end
      MODE_SCF: begin
        out_o.flags = '{z: flags_i.z, n: 1'b0, h: 1'b0, c: 1'b1};
      end
      MODE_CCF: begin
        out_o.flags = '{z: flags_i.z, n: 1'b0, h: 1'b0, c: ~flags_i.c};
      end
      MODE_RLCA, MODE_RRCA, MODE_RLA, MODE_RRA: begin
        out_o.acc    = sh_val;
        out_o.result = sh_val;
        out_o.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: sh_carry};
      end
      MODE_RLC, MODE_RRC, MODE_RL, MODE_RR,
      MODE_SLA, MODE_SRA, MODE_SWAP, MODE_SRL: begin
        out_o.result = sh_val;
        out_o.flags  = '{z: (sh_val == 8'd0), n: 1'b0, h: 1'b0, c: sh_carry};
      end
      MODE_BIT: begin
        out_o.result = operand_i;
        out_o.flags  = '{z: ((operand_i & bit_mask) == 8'd0), n: 1'b0, h: 1'b1,
                         c: flags_i.c};
      end
      MODE_RES: begin
        out_o.result = operand_i & ~bit_mask;
      end
      MODE_SET: begin
        out_o.result = operand_i | bit_mask;
      end
      MODE_LOAD: begin
        out_o.acc    = operand_i;
        out_o.result = operand_i;
        out_o.flags  = flags_t'(flags_in_i);
      end
      default: begin
        // unused codes leave everything as it is
        out_o.result = acc_i;
      end
    endcase
  end

endmodule
